[rtl/sitr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitr_pkg: shared definitions for the signed integer to radix text block
// Holds the register map, symbol table layout, byte codes and the status
// struct passed between the table checker and the top level.
// ----------------------------------------------------------------------------
package sitr_pkg;

  // Configuration register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_MID_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_MID_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH     = 3'd4;

  // Symbol table layout: four 64-bit registers, eight bytes each.
  localparam int BYTE_W    = 8;
  localparam int SYM_REGS  = 4;
  localparam int SYM_SLOTS = 32;
  localparam int SYM_IDX_W = 5;
  localparam int RADIX_W   = 6;

  // Quotient bits produced by the divider in each cycle.
  localparam int STEP_BITS = 8;

  localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'h2B;
  localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;

  localparam int DEF_MAX_SYMBOLS = 32;
  localparam int DEF_VALUE_BITS  = 32;

  typedef logic [SYM_REGS-1:0][CFG_DATA_W-1:0] sym_regs_t;
  typedef logic [SYM_SLOTS-1:0][BYTE_W-1:0]    sym_table_t;

  typedef struct packed {
    logic done;
    logic valid;
  } chk_status_t;

endpackage : sitr_pkg
`default_nettype wire

[rtl/sitr_table_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitr_table_check: iterative symbol table validation
// Walks the symbols in use one per cycle, comparing each against the sign
// bytes and against every later symbol in parallel.
// ----------------------------------------------------------------------------
module sitr_table_check import sitr_pkg::*; #(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [RADIX_W-1:0]   radix,
  input  wire sym_table_t           symbols,
  output chk_status_t               status
);

  logic                 busy;
  logic [SYM_IDX_W-1:0] pos;
  logic [BYTE_W-1:0]    cur;
  logic                 bad;
  logic                 range_bad;
  logic                 at_end;

  always_comb begin
    cur = symbols[pos];
    bad = (cur == PLUS_BYTE) || (cur == MINUS_BYTE);
    for (int j = 0; j < SYM_SLOTS; j++) begin
      if ((RADIX_W'(j) > {1'b0, pos}) && (RADIX_W'(j) < radix) && (symbols[j] == cur)) begin
        bad = 1'b1;
      end
    end
  end

  assign range_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_SYMBOLS));
  assign at_end    = ({1'b0, pos} == radix - RADIX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      status <= '0;
    end else begin
      status.done <= start ? range_bad : (busy && (bad || at_end));
      if (start) begin
        if (range_bad) begin
          status.valid <= 1'b0;
        end else begin
          busy <= 1'b1;
          pos  <= '0;
        end
      end else if (busy) begin
        if (bad) begin
          busy         <= 1'b0;
          status.valid <= 1'b0;
        end else if (at_end) begin
          busy         <= 1'b0;
          status.valid <= 1'b1;
        end else begin
          pos <= pos + SYM_IDX_W'(1);
        end
      end
    end
  end

endmodule : sitr_table_check
`default_nettype wire

[rtl/sitr_div_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitr_div_unit: shared restoring divider
// Divides the work word by the radix, several quotient bits per cycle, and
// returns quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module sitr_div_unit import sitr_pkg::*; #(
  parameter int WORK_BITS = DEF_VALUE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORK_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]   divisor,
  output logic                      done,
  output logic [WORK_BITS-1:0]      quotient,
  output logic [RADIX_W-1:0]        remainder
);

  localparam int STEPS = WORK_BITS / STEP_BITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [WORK_BITS-1:0] acc;
  logic [RADIX_W-1:0]   rem;
  logic [WORK_BITS-1:0] acc_next;
  logic [RADIX_W-1:0]   rem_next;

  // The partial remainder stays below the divisor, so its top bit is free
  // for the shift.
  always_comb begin
    acc_next = acc;
    rem_next = rem;
    for (int b = 0; b < STEP_BITS; b++) begin
      rem_next = {rem_next[RADIX_W-2:0], acc_next[WORK_BITS-1]};
      acc_next = {acc_next[WORK_BITS-2:0], 1'b0};
      if (rem_next >= divisor) begin
        rem_next    = rem_next - divisor;
        acc_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        rem <= rem_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = acc;
  assign remainder = rem;

endmodule : sitr_div_unit
`default_nettype wire

[rtl/signed_integer_to_radix_text.sv]
// Steps: the value is taken, the symbol table is checked (no walk when the
// length is out of range), each digit comes from the shared divider at eight
// quotient bits per cycle, and the bytes go out at one per cycle while the
// receiver is ready. Throughput: one number at a time.
// Reset (rst, synchronous) clears the config registers, sequencer and out_valid.
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: signed integer to text in a chosen radix
// Validates the symbol table, divides the magnitude down one digit at a time
// and streams the sign and digit symbols out, most significant first.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text import sitr_pkg::*; #(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] value,
  // Output channel.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [BYTE_W-1:0]                 out_char,
  output logic                              last,
  // Configuration write channel.
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  // The work word is padded to whole divider steps.
  localparam int WORK_BITS = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int DIGIT_W   = $clog2(MAX_SYMBOLS);
  localparam int IDX_W     = $clog2(VALUE_BITS);
  localparam int CNT_W     = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t               state;

  // Configuration registers.
  logic [RADIX_W-1:0]   radix_length;
  sym_regs_t            symbol_regs;
  sym_table_t           sym_table;

  // Working state of the current number.
  logic [DIGIT_W-1:0]   digit_store [VALUE_BITS];
  logic [CNT_W-1:0]     digit_count;
  logic [WORK_BITS-1:0] magnitude_work;
  logic                 negative;
  logic                 sign_pending;

  // Links to the checker and the divider.
  logic                 chk_start;
  chk_status_t          chk_status;
  logic                 div_start;
  logic [WORK_BITS-1:0] div_dividend;
  logic                 div_done;
  logic [WORK_BITS-1:0] div_quotient;
  logic [RADIX_W-1:0]   div_remainder;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      cnt_dec2;
  logic [IDX_W-1:0]      rd_addr;
  logic [DIGIT_W-1:0]    rd_digit;
  logic [BYTE_W-1:0]     rd_symbol;
  logic                  emit_load;

  // The four symbol registers laid end to end form the byte table, with
  // symbol 0 in the lowest byte of the first register.
  assign sym_table = symbol_regs;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign chk_start = in_valid && in_ready;

  // The magnitude is taken in unsigned arithmetic of the value's width, so the
  // most negative value comes out as its true magnitude.
  assign raw    = value;
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // The divider is started once the table is known to be good, and again
  // straight after each digit while the quotient is still non-zero.
  assign div_start = ((state == ST_CHECK) && chk_status.done && chk_status.valid) ||
                     ((state == ST_DIVIDE) && div_done && (div_quotient != '0));
  assign div_dividend = (state == ST_DIVIDE) ? div_quotient : magnitude_work;

  // Digits were stored least significant first, so they are read back from
  // the top of the store downwards. The store is read ahead: the address is the
  // entry that the next byte will need, so when a digit byte leaves in this
  // cycle the entry below the current top is fetched.
  assign cnt_dec   = digit_count - CNT_W'(1);
  assign cnt_dec2  = digit_count - CNT_W'(2);
  assign rd_addr   = (emit_load && !sign_pending) ? cnt_dec2[IDX_W-1:0] : cnt_dec[IDX_W-1:0];
  assign rd_symbol = sym_table[SYM_IDX_W'(rd_digit)];

  // While emitting, a new byte goes into the output register whenever it is
  // empty or its contents are being transferred in this cycle.
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);

  sitr_table_check #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (chk_start),
    .radix   (radix_length),
    .symbols (sym_table),
    .status  (chk_status)
  );

  sitr_div_unit #(
    .WORK_BITS (WORK_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_length),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Digit store: one entry written per finished division. The digit just
  // written becomes the new top of the store, so it is passed straight to the
  // read register rather than read back.
  always_ff @(posedge clk) begin
    if ((state == ST_DIVIDE) && div_done) begin
      digit_store[digit_count[IDX_W-1:0]] <= div_remainder[DIGIT_W-1:0];
      rd_digit                            <= div_remainder[DIGIT_W-1:0];
    end else begin
      rd_digit <= digit_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      radix_length   <= '0;
      symbol_regs    <= '0;
      digit_count    <= '0;
      magnitude_work <= '0;
      negative       <= 1'b0;
      sign_pending   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Configuration transfers; indexes beyond the register list are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIX_LENGTH:     radix_length   <= cfg_data[RADIX_W-1:0];
          REG_SYMBOLS_LOW:      symbol_regs[0] <= cfg_data;
          REG_SYMBOLS_MID_LOW:  symbol_regs[1] <= cfg_data;
          REG_SYMBOLS_MID_HIGH: symbol_regs[2] <= cfg_data;
          REG_SYMBOLS_HIGH:     symbol_regs[3] <= cfg_data;
          default: ;
        endcase
      end

      // The output register empties on a transfer unless the next byte is
      // loaded into it in the same cycle.
      if (out_valid && out_ready && !emit_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (chk_start) begin
            negative       <= raw[VALUE_BITS-1];
            magnitude_work <= WORK_BITS'(mag_in);
            state          <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          // A bad table drops the number without any output.
          if (chk_status.done) begin
            if (chk_status.valid) begin
              digit_count <= '0;
              state       <= ST_DIVIDE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end

        ST_DIVIDE: begin
          if (div_done) begin
            digit_count    <= digit_count + CNT_W'(1);
            magnitude_work <= div_quotient;
            if (div_quotient == '0) begin
              sign_pending <= negative;
              state        <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          if (emit_load) begin
            out_valid <= 1'b1;
            if (sign_pending) begin
              out_char     <= MINUS_BYTE;
              last         <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              out_char    <= rd_symbol;
              last        <= (digit_count == CNT_W'(1));
              digit_count <= cnt_dec;
              if (digit_count == CNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : signed_integer_to_radix_text
`default_nettype wire

[rtl/sitr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitr_checker: port-level assertions for the radix text block
// Watches the handshakes and the byte stream of the top level.
// ----------------------------------------------------------------------------
module sitr_checker import sitr_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_char,
  input wire logic              last
);

  // A stalled byte holds until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(last)))
    else $error("output byte changed while stalled");

  // Only one number is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a number is in work");

  // The minus sign can never be a digit symbol, so it never ends the text.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_char == MINUS_BYTE)) |-> !last)
    else $error("minus sign marked as last byte");

  // Bytes of one number follow each other without a gap.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("gap inside the text of a number");

endmodule : sitr_checker

bind signed_integer_to_radix_text sitr_checker u_sitr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .last      (last)
);
`default_nettype wire

[tb/tb_signed_integer_to_radix_text.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_text: self-checking bench for radix text output
// Loads symbol tables through the register port and sends signed values.
// Every text byte is checked against fixed text or a local model of the
// rendering, under four pacing modes on the input and output channels.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_text;
  timeunit 1ns;
  timeprecision 1ps;
  import sitr_pkg::*;

  localparam int RESET_CYCLES  = 9;
  // The slowest legal item (radix 2, 32 digits) needs a full table walk, a
  // divider pass per digit and 33 output bytes. An item under a broken table
  // gives no bytes, but the table walk may still be running when the last
  // expected byte of the previous item has gone, so the bench waits this long
  // before it touches the registers again.
  localparam int SETTLE_CYCLES = 80;
  // The worst correct run is roughly 450 items of 33 bytes each, every byte
  // held back by a long receiver stall, and the limit sits well above that.
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 400;
  localparam int PHASES        = 4;
  localparam int DIRECTED_ROWS = 23;

  // Register indexes above the last symbol register are unmapped, and writes
  // to them must leave the table alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_SYMBOLS_HIGH + 1'b1;

  // Pacing per phase: free running, sender gaps, receiver stalls, then both.
  localparam int SENDER_IDLE_PCT [PHASES]    = '{0, 49, 0, 13};
  localparam int RECEIVER_STALL_PCT [PHASES] = '{0, 0, 49, 13};

  // Symbol tables used by the directed rows.
  typedef enum {
    TBL_AS_RESET,
    TBL_DECIMAL,
    TBL_BINARY,
    TBL_HEX,
    TBL_FULL_WIDTH,
    TBL_SINGLE,
    TBL_OVERSIZE,
    TBL_FIELD_MAX,
    TBL_WITH_PLUS,
    TBL_WITH_MINUS,
    TBL_REPEATED,
    TBL_TAIL_IGNORED
  } table_kind_t;

  // One directed row. Where typed is set, text holds the exact bytes that must
  // come back (an empty string means the item must give no bytes at all);
  // otherwise the expected text comes from the local model.
  typedef struct {
    table_kind_t                      kind;
    logic signed [DEF_VALUE_BITS-1:0] num;
    bit                               typed;
    string                            text;
  } directed_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } text_byte_t;

  // --------------------------------------------------------------------------
  // Signals. Every input of the block holds a known value from time zero.
  // --------------------------------------------------------------------------
  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic signed [DEF_VALUE_BITS-1:0] value     = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [BYTE_W-1:0]                out_char;
  logic                             last;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [CFG_IDX_W-1:0]             cfg_index = '0;
  logic [CFG_DATA_W-1:0]            cfg_data  = '0;

  // The bench's own copy of the registers, updated on each accepted write.
  logic [RADIX_W-1:0] radix_len_cfg = '0;
  sym_regs_t          symbol_cfg    = '0;

  // Bytes still owed by the block, oldest first.
  text_byte_t expected_text_q [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatch_count     = 0;
  int bytes_checked      = 0;
  int numbers_sent       = 0;
  int tables_loaded      = 0;
  int cycle_count        = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // Nothing written yet: length 0 means the table is unusable.
    '{TBL_AS_RESET,     32'sd5,           1'b1, ""},
    // Decimal, with junk in the unused upper bits of the length register.
    '{TBL_DECIMAL,      32'sd0,           1'b1, "0"},
    '{TBL_DECIMAL,      32'sh7FFF_FFFF,   1'b1, "2147483647"},
    '{TBL_DECIMAL,      32'sh8000_0000,   1'b1, "-2147483648"},
    '{TBL_DECIMAL,      32'shFFFF_FFFF,   1'b1, "-1"},
    '{TBL_DECIMAL,      32'sd1000,        1'b0, ""},
    // Smallest radix: the longest texts the block can produce.
    '{TBL_BINARY,       32'sd5,           1'b1, "101"},
    '{TBL_BINARY,       32'sh8000_0000,   1'b0, ""},
    '{TBL_BINARY,       32'sh7FFF_FFFF,   1'b0, ""},
    '{TBL_HEX,          32'sh8000_0000,   1'b1, "-80000000"},
    '{TBL_HEX,          32'shDEAD_BEEF,   1'b0, ""},
    // Largest radix, with a zero byte as symbol 0 and 0xFF as symbol 31.
    '{TBL_FULL_WIDTH,   32'sd0,           1'b0, ""},
    '{TBL_FULL_WIDTH,   32'sd31,          1'b0, ""},
    '{TBL_FULL_WIDTH,   32'sh8000_0000,   1'b0, ""},
    '{TBL_FULL_WIDTH,   32'sh7FFF_FFFF,   1'b0, ""},
    // Unusable tables: every one of these must stay silent.
    '{TBL_SINGLE,       32'sd7,           1'b1, ""},
    '{TBL_OVERSIZE,     32'sd7,           1'b1, ""},
    '{TBL_FIELD_MAX,    -32'sd7,          1'b1, ""},
    '{TBL_WITH_PLUS,    32'sd3,           1'b1, ""},
    '{TBL_WITH_MINUS,   32'sd3,           1'b1, ""},
    '{TBL_REPEATED,     32'sd3,           1'b1, ""},
    // Sign bytes and a repeat beyond the length are outside the table.
    '{TBL_TAIL_IGNORED, 32'sd5,           1'b1, "bc"},
    '{TBL_TAIL_IGNORED, -32'sd4,          1'b1, "-bb"}
  };

  signed_integer_to_radix_text dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // --------------------------------------------------------------------------
  // Text model. Symbol k sits in byte k of the 256-bit table, so register
  // k/8 holds it at byte k%8.
  // --------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] symbol_slot(input int k);
    return symbol_cfg[k / 8][(k % 8) * BYTE_W +: BYTE_W];
  endfunction

  // A table is usable when its length lies in 2..MAX_SYMBOLS and the symbols
  // in use hold no sign byte and no repeat. Bytes past the length are ignored.
  function automatic bit table_usable();
    int n;
    n = radix_len_cfg;
    if (n < 2 || n > DEF_MAX_SYMBOLS) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (symbol_slot(i) == PLUS_BYTE || symbol_slot(i) == MINUS_BYTE) begin
        return 1'b0;
      end
      for (int j = i + 1; j < n; j++) begin
        if (symbol_slot(j) == symbol_slot(i)) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Queues the text of one number: a minus byte for negative values, then the
  // digits most significant first, the final byte flagged as last. Taking the
  // two's complement as an unsigned 32-bit quantity gives 2^31 for the most
  // negative value, so no wider arithmetic is needed here.
  task automatic predict_text(input logic signed [DEF_VALUE_BITS-1:0] num);
    logic [DEF_VALUE_BITS-1:0] magnitude;
    logic [DEF_VALUE_BITS-1:0] radix;
    logic [SYM_IDX_W-1:0]      digits [$];
    if (!table_usable()) begin
      return;
    end
    radix     = DEF_VALUE_BITS'(radix_len_cfg);
    magnitude = num[DEF_VALUE_BITS-1] ? (~num + 1'b1) : num;
    do begin
      digits.push_front(SYM_IDX_W'(magnitude % radix));
      magnitude = magnitude / radix;
    end while (magnitude != 0);
    if (num[DEF_VALUE_BITS-1]) begin
      expected_text_q.push_back('{MINUS_BYTE, 1'b0});
    end
    foreach (digits[i]) begin
      expected_text_q.push_back('{symbol_slot(digits[i]), i == digits.size() - 1});
    end
  endtask

  // --------------------------------------------------------------------------
  // Register port. The bench's copy changes only when the write is accepted.
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0]  index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_RADIX_LENGTH: begin
        radix_len_cfg = data[RADIX_W-1:0];
      end
      REG_SYMBOLS_LOW, REG_SYMBOLS_MID_LOW, REG_SYMBOLS_MID_HIGH, REG_SYMBOLS_HIGH: begin
        symbol_cfg[index - REG_SYMBOLS_LOW] = data;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes the length register and all four symbol registers, and now and
  // then a stray write to an unmapped index, which must change nothing.
  task automatic load_table(input logic [CFG_DATA_W-1:0] radix_data,
                            input sym_table_t            tbl);
    sym_regs_t regs;
    regs = sym_regs_t'(tbl);
    write_register(REG_RADIX_LENGTH, radix_data);
    for (int r = 0; r < SYM_REGS; r++) begin
      write_register(CFG_IDX_W'(int'(REG_SYMBOLS_LOW) + r), regs[r]);
    end
    if ($urandom_range(0, 1) == 1) begin
      write_register(CFG_IDX_W'($urandom_range(int'(REG_UNMAPPED_FIRST),
                                               (1 << CFG_IDX_W) - 1)),
                     {$urandom, $urandom});
    end
    tables_loaded++;
  endtask

  function automatic sym_table_t text_table(input string s);
    sym_table_t tbl;
    tbl = '0;
    for (int k = 0; k < s.len(); k++) begin
      tbl[k] = s[k];
    end
    return tbl;
  endfunction

  // All 32 slots distinct, with the zero byte first and 0xFF last.
  function automatic sym_table_t full_width_table();
    sym_table_t tbl;
    for (int k = 0; k < SYM_SLOTS; k++) begin
      tbl[k] = BYTE_W'(8'h41 + k);
    end
    tbl[0]             = 8'h00;
    tbl[SYM_SLOTS - 1] = 8'hFF;
    return tbl;
  endfunction

  // The first count slots get distinct bytes other than the sign bytes; the
  // rest are left fully random, signs and repeats included.
  function automatic sym_table_t random_symbols(input int count);
    sym_table_t        tbl;
    bit [255:0]        used;
    logic [BYTE_W-1:0] pick;
    used = '0;
    for (int k = 0; k < SYM_SLOTS; k++) begin
      tbl[k] = BYTE_W'($urandom);
      if (k < count) begin
        do begin
          pick = BYTE_W'($urandom);
        end while (used[pick] || pick == PLUS_BYTE || pick == MINUS_BYTE);
        used[pick] = 1'b1;
        tbl[k]     = pick;
      end
    end
    return tbl;
  endfunction

  task automatic apply_directed_table(input table_kind_t kind);
    case (kind)
      TBL_DECIMAL:      load_table(64'hFFFF_FFFF_FFFF_FFCA, text_table("0123456789"));
      TBL_BINARY:       load_table(CFG_DATA_W'(2), text_table("01"));
      TBL_HEX:          load_table(CFG_DATA_W'(16), text_table("0123456789abcdef"));
      TBL_FULL_WIDTH:   load_table(CFG_DATA_W'(32), full_width_table());
      TBL_SINGLE:       load_table(CFG_DATA_W'(1), text_table("0123456789"));
      TBL_OVERSIZE:     load_table(CFG_DATA_W'(33), full_width_table());
      TBL_FIELD_MAX:    load_table({CFG_DATA_W{1'b1}}, full_width_table());
      TBL_WITH_PLUS:    load_table(CFG_DATA_W'(4), text_table("01+3"));
      TBL_WITH_MINUS:   load_table(CFG_DATA_W'(4), text_table("-123"));
      TBL_REPEATED:     load_table(CFG_DATA_W'(5), text_table("01231"));
      TBL_TAIL_IGNORED: load_table(CFG_DATA_W'(3), text_table("abc+-a"));
      default: begin
      end
    endcase
  endtask

  // Mostly usable tables, weighted towards the smallest and largest radix.
  // About one load in seven is broken: a length out of range, a sign byte in
  // use, or a repeated symbol. The upper bits of the length word are random.
  task automatic load_random_table();
    int                    count;
    int                    spot;
    sym_table_t            tbl;
    logic [CFG_DATA_W-1:0] radix_data;
    case ($urandom_range(0, 6))
      0: count = 2;
      1: count = 32;
      default: count = $urandom_range(2, 32);
    endcase
    tbl = random_symbols(count);
    if ($urandom_range(0, 6) == 0) begin
      spot = $urandom_range(0, count - 1);
      case ($urandom_range(0, 3))
        0: count = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
        1: tbl[spot] = PLUS_BYTE;
        2: tbl[spot] = MINUS_BYTE;
        default: tbl[count - 1] = tbl[$urandom_range(0, count - 2)];
      endcase
    end
    radix_data                = {$urandom, $urandom};
    radix_data[RADIX_W-1:0]   = RADIX_W'(count);
    load_table(radix_data, tbl);
  endtask

  // Extremes now and then, short texts often, full-range values the rest.
  function automatic logic signed [DEF_VALUE_BITS-1:0] random_value();
    logic [DEF_VALUE_BITS-1:0] short_num;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sd0;
          3: return 32'shFFFF_FFFF;
          default: return 32'sd1;
        endcase
      end
      1, 2: begin
        short_num = $urandom_range(0, 4095);
        return ($urandom_range(0, 1) == 1) ? -short_num : short_num;
      end
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Valid goes up at a falling edge and stays up, value held,
  // until the rising edge at which the transfer happens. The expected text is
  // queued at that edge, with the registers as they stand then.
  // --------------------------------------------------------------------------
  task automatic send_value(input logic signed [DEF_VALUE_BITS-1:0] num,
                            input bit typed, input string text);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    do @(posedge clk); while (!in_ready);
    numbers_sent++;
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        expected_text_q.push_back('{text[i], i == text.len() - 1});
      end
    end else begin
      predict_text(num);
    end
  endtask

  // Drops valid, waits for every owed byte, then lets a broken-table item
  // finish its walk so that the registers can be written safely.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready is re-rolled at every falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Each byte transfer is checked against the oldest owed byte, field by field.
  always @(posedge clk) begin
    text_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte: out_char %02h last %0b", out_char, last));
      end else begin
        want = expected_text_q.pop_front();
        bytes_checked++;
        if (out_char !== want.ch) begin
          report_mismatch($sformatf("out_char: expected %02h, got %02h", want.ch, out_char));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last: expected %0b, got %0b (out_char %02h)",
                                    want.last, last, out_char));
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d bytes still owed.",
               expected_text_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed rows, then randomised tables and values in four
  // pacing phases.
  // --------------------------------------------------------------------------
  initial begin
    table_kind_t current_kind;
    int          phase_numbers;
    int          burst;
    bit          usable;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first rows run against the table as it comes out of reset; a new
    // table is loaded only once the block has gone quiet.
    current_kind = TBL_AS_RESET;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind != current_kind) begin
        wait_until_drained();
        apply_directed_table(directed_rows[r].kind);
        current_kind = directed_rows[r].kind;
      end
      send_value(directed_rows[r].num, directed_rows[r].typed, directed_rows[r].text);
    end

    // Items sent under a broken table give no text, so they do not count
    // towards the number of items each phase is meant to render.
    for (int phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct    = SENDER_IDLE_PCT[phase];
      receiver_stall_pct = RECEIVER_STALL_PCT[phase];
      phase_numbers      = 0;
      while (phase_numbers < RANDOM_ITEMS / PHASES) begin
        wait_until_drained();
        load_random_table();
        usable = table_usable();
        burst  = usable ? $urandom_range(8, 25) : $urandom_range(2, 4);
        for (int i = 0; i < burst; i++) begin
          send_value(random_value(), 1'b0, "");
        end
        if (usable) begin
          phase_numbers += burst;
        end
      end
    end

    wait_until_drained();
    $display("Sent %0d numbers under %0d loaded tables; %0d text bytes compared, %0d bad.",
             numbers_sent, tables_loaded, bytes_checked, mismatch_count);
    $display("Radices 2 to 32, broken tables and four pacing modes were exercised.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : tb_signed_integer_to_radix_text
`default_nettype wire

[sim.f]
rtl/sitr_pkg.sv
rtl/sitr_table_check.sv
rtl/sitr_div_unit.sv
rtl/signed_integer_to_radix_text.sv
rtl/sitr_checker.sv
tb/tb_signed_integer_to_radix_text.sv
